>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> sv/bpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpsd_pkg;

  localparam int MAX_SUBS_DEF = 255;
  localparam int MAX_RUN_DEF  = 64;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_BAD_HDR  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    PH_FIRST_HI, PH_FIRST_LO, PH_HI, PH_LO, PH_COUNT, PH_PAIRS, PH_CODES, PH_DATA
  } phase_e;

  typedef enum logic [2:0] {
    CMD_PAIR_HI, CMD_PAIR_LO, CMD_CODE, CMD_EXPAND, CMD_BAD_HDR
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
    logic [7:0] idx;
    logic       last_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SEARCH, BK_CMP, BK_PAIR, BK_POP, BK_READ, BK_EMIT, BK_SINGLE
  } bk_state_e;

endpackage
`default_nettype wire

>>> sv/bpsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bpsd_front #(
  parameter int MAX_SUBS = bpsd_pkg::MAX_SUBS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            stream_last_i,
  output logic            cmd_valid_o,
  output bpsd_pkg::cmd_t  cmd_o,
  input  logic            cmd_full_i
);
  import bpsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  hh_q, hh_d;
  logic [15:0] left_q, left_d;
  logic [15:0] blen_q, blen_d;
  logic [7:0]  subs_q, subs_d;
  logic        err_q, err_d;

  logic        accept;
  logic [15:0] left_dec;
  logic [15:0] pair_pos;
  logic [7:0]  code_pos;
  logic [7:0]  cnt;
  logic [15:0] hdr;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;
  assign left_dec   = left_q - 16'd1;
  assign pair_pos   = {7'd0, subs_q, 1'b0} - left_q;
  assign code_pos   = subs_q - left_q[7:0];
  assign cnt        = (in_byte_i > 8'(MAX_SUBS)) ? 8'(MAX_SUBS) : in_byte_i;
  assign hdr        = {hh_q, in_byte_i};

  always_comb begin
    phase_d     = phase_q;
    hh_d        = hh_q;
    left_d      = left_q;
    blen_d      = blen_q;
    subs_d      = subs_q;
    err_d       = err_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{kind: CMD_CODE, data: in_byte_i, idx: 8'd0, last_byte: 1'b0};
    if (accept) begin
      if (!err_q) begin
        unique case (phase_q)
          PH_FIRST_HI: begin
            hh_d    = in_byte_i;
            phase_d = PH_FIRST_LO;
          end
          PH_HI: begin
            hh_d    = in_byte_i;
            phase_d = PH_LO;
          end
          PH_FIRST_LO: begin
            if (hdr != 16'd0) begin
              err_d       = 1'b1;
              cmd_valid_o = 1'b1;
              cmd_o.kind  = CMD_BAD_HDR;
              phase_d     = PH_HI;
            end else begin
              phase_d = PH_COUNT;
            end
          end
          PH_LO: begin
            blen_d = hdr;
            if (hdr == 16'd0) begin
              phase_d = PH_COUNT;
            end else if (subs_q != 8'd0) begin
              left_d  = {8'd0, subs_q};
              phase_d = PH_CODES;
            end else begin
              left_d  = hdr;
              phase_d = PH_DATA;
            end
          end
          PH_COUNT: begin
            subs_d = cnt;
            if (cnt == 8'd0) begin
              phase_d = PH_HI;
            end else begin
              left_d  = {7'd0, cnt, 1'b0};
              phase_d = PH_PAIRS;
            end
          end
          PH_PAIRS: begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = pair_pos[0] ? CMD_PAIR_LO : CMD_PAIR_HI;
            cmd_o.idx   = pair_pos[8:1];
            left_d      = left_dec;
            if (left_dec == 16'd0) phase_d = PH_HI;
          end
          PH_CODES: begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CMD_CODE;
            cmd_o.idx   = code_pos;
            left_d      = left_dec;
            if (left_dec == 16'd0) begin
              left_d  = blen_q;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            cmd_valid_o     = 1'b1;
            cmd_o.kind      = CMD_EXPAND;
            cmd_o.idx       = subs_q;
            cmd_o.last_byte = (left_dec == 16'd0);
            left_d          = left_dec;
            if (left_dec == 16'd0) phase_d = PH_HI;
          end
        endcase
      end
      if (stream_last_i) begin
        phase_d = PH_FIRST_HI;
        err_d   = 1'b0;
        left_d  = 16'd0;
        hh_d    = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST_HI;
      hh_q    <= 8'd0;
      left_q  <= 16'd0;
      blen_q  <= 16'd0;
      subs_q  <= 8'd0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hh_q    <= hh_d;
      left_q  <= left_d;
      blen_q  <= blen_d;
      subs_q  <= subs_d;
      err_q   <= err_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/bpsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bpsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpsd_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output bpsd_pkg::cmd_t cmd_o,
  input  logic           pop_i
);
  import bpsd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule
`default_nettype wire

>>> sv/bpsd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bpsd_back #(
  parameter int MAX_RUN = bpsd_pkg::MAX_RUN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  bpsd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     status_o,
  output logic           run_last_o,
  output logic           block_end_o
);
  import bpsd_pkg::*;

  localparam int RUN_DEPTH = MAX_RUN - 1;
  localparam int RUN_AW    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int N_W       = $clog2(MAX_RUN);

  bk_state_e      state_q, state_d;
  logic [7:0]     x_q, x_d;
  logic [7:0]     s_q, s_d;
  logic [8:0]     sp_q, sp_d;
  logic [N_W-1:0] n_q, n_d, k_q, k_d;
  logic           fin_q, fin_d;
  logic [1:0]     st_q, st_d;

  logic [7:0]  code_mem    [256];
  logic [7:0]  pair_hi_mem [256];
  logic [7:0]  pair_lo_mem [256];
  logic [15:0] stack_mem   [256];
  logic [7:0]  run_mem     [RUN_DEPTH];

  logic [7:0]  code_rd_q, pair_hi_rd_q, pair_lo_rd_q, run_rd_q;
  logic [15:0] stack_rd_q;

  logic        code_we, pair_hi_we, pair_lo_we, stack_we, run_we;
  logic [7:0]  code_raddr, pair_raddr, stack_raddr;
  logic [15:0] stack_wdata;
  logic        leaf_full, stack_full, out_free, emit_last;

  logic       out_valid_q, out_load;
  logic [7:0] out_byte_q, out_byte_d;
  logic [1:0] status_q, status_d;
  logic       run_last_q, run_last_d, block_end_q, block_end_d;

  assign leaf_full  = (n_q >= N_W'(RUN_DEPTH));
  assign stack_full = (sp_q >= 9'd255);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_last  = (k_q == n_q - N_W'(1));
  assign cmd_pop_o  = (state_q == BK_IDLE) && cmd_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_EXPAND)       state_d = BK_SEARCH;
          else if (cmd_i.kind == CMD_BAD_HDR) state_d = BK_SINGLE;
        end
      end
      BK_SEARCH: begin
        if (s_q != 8'd0)        state_d = BK_CMP;
        else if (leaf_full)     state_d = BK_SINGLE;
        else if (sp_q == 9'd0)  state_d = BK_READ;
        else                    state_d = BK_POP;
      end
      BK_CMP:    state_d = (code_rd_q == x_q) ? BK_PAIR : BK_SEARCH;
      BK_PAIR:   state_d = stack_full ? BK_SINGLE : BK_SEARCH;
      BK_POP:    state_d = BK_SEARCH;
      BK_READ:   state_d = BK_EMIT;
      BK_EMIT:   if (out_free) state_d = emit_last ? BK_IDLE : BK_READ;
      BK_SINGLE: if (out_free) state_d = BK_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    x_d = x_q; s_d = s_q; sp_d = sp_q; n_d = n_q; k_d = k_q; fin_d = fin_q; st_d = st_q;
    code_we = 1'b0; pair_hi_we = 1'b0; pair_lo_we = 1'b0;
    stack_we = 1'b0; run_we = 1'b0;
    code_raddr  = s_q - 8'd1;
    pair_raddr  = s_q;
    stack_raddr = 8'(sp_q - 9'd1);
    stack_wdata = {s_q, pair_lo_rd_q};
    out_load = 1'b0;
    out_byte_d = 8'd0; status_d = ST_DATA; run_last_d = 1'b1; block_end_d = fin_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_PAIR_HI: pair_hi_we = 1'b1;
            CMD_PAIR_LO: pair_lo_we = 1'b1;
            CMD_CODE:    code_we    = 1'b1;
            CMD_EXPAND: begin
              x_d   = cmd_i.data;
              s_d   = cmd_i.idx;
              sp_d  = 9'd0;
              n_d   = '0;
              k_d   = '0;
              fin_d = cmd_i.last_byte;
            end
            CMD_BAD_HDR: begin
              st_d  = ST_BAD_HDR;
              fin_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      BK_SEARCH: begin
        if (s_q != 8'd0) begin
          s_d = s_q - 8'd1;
        end else if (leaf_full) begin
          st_d = ST_OVERFLOW;
        end else begin
          run_we = 1'b1;
          n_d    = n_q + N_W'(1);
          if (sp_q != 9'd0) sp_d = sp_q - 9'd1;
        end
      end
      BK_CMP: ;
      BK_PAIR: begin
        if (stack_full) begin
          st_d = ST_OVERFLOW;
        end else begin
          stack_we = 1'b1;
          sp_d     = sp_q + 9'd1;
          x_d      = pair_hi_rd_q;
        end
      end
      BK_POP: begin
        x_d = stack_rd_q[7:0];
        s_d = stack_rd_q[15:8];
      end
      BK_READ: ;
      BK_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_byte_d  = run_rd_q;
          run_last_d  = emit_last;
          block_end_d = emit_last && fin_q;
          k_d         = k_q + N_W'(1);
        end
      end
      BK_SINGLE: begin
        if (out_free) begin
          out_load = 1'b1;
          status_d = st_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (code_we)    code_mem[cmd_i.idx]    <= cmd_i.data;
    if (pair_hi_we) pair_hi_mem[cmd_i.idx] <= cmd_i.data;
    if (pair_lo_we) pair_lo_mem[cmd_i.idx] <= cmd_i.data;
    if (stack_we)   stack_mem[sp_q[7:0]]   <= stack_wdata;
    if (run_we)     run_mem[n_q[RUN_AW-1:0]] <= x_q;
    code_rd_q    <= code_mem[code_raddr];
    pair_hi_rd_q <= pair_hi_mem[pair_raddr];
    pair_lo_rd_q <= pair_lo_mem[pair_raddr];
    stack_rd_q   <= stack_mem[stack_raddr];
    run_rd_q     <= run_mem[k_q[RUN_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    s_q   <= s_d;
    sp_q  <= sp_d;
    n_q   <= n_d;
    k_q   <= k_d;
    fin_q <= fin_d;
    st_q  <= st_d;
    if (out_load) begin
      out_byte_q  <= out_byte_d;
      status_q    <= status_d;
      run_last_q  <= run_last_d;
      block_end_q <= block_end_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign run_last_o  = run_last_q;
  assign block_end_o = block_end_q;

endmodule
`default_nettype wire

>>> sv/byte_pair_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Byte-pair stream decoder. Takes one compressed byte per transfer and streams
// the decoded bytes out, one transfer per byte. A stream opens with a zero
// size word (init block: substitution count, then the pair table); any other
// opening word gives one status 1 result and the rest of the stream is ignored.
// Later nonzero size words open data blocks (code table, then data bytes).
// A data byte whose expansion reaches MAX_RUN bytes, or whose expansion stack
// would reach 256 entries, gives one status 2 result in place of its bytes.
// A data byte leaves the queue, then the engine searches the code table one
// probe at a time (one read port, registered data), applies each substitution
// found, takes leaves off the expansion stack, and reads each output byte back
// from the run buffer. The serial code-table search sets the worst case: with
// 255 substitutions, up to 63 leaves can each probe close to the whole table.
// A 4-entry command queue lets the parser keep taking table and header bytes
// while expansion runs; once it fills, the input stalls.
module byte_pair_stream_decoder #(
  parameter int MAX_SUBS = bpsd_pkg::MAX_SUBS_DEF,
  parameter int MAX_RUN  = bpsd_pkg::MAX_RUN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_last_o,
  output logic       block_end_o
);
  import bpsd_pkg::*;

  // parser -> queue
  logic push, q_full;
  cmd_t push_cmd;
  // queue -> expansion engine
  logic q_valid, q_pop;
  cmd_t head_cmd;

  bpsd_front #(.MAX_SUBS(MAX_SUBS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_byte_i, .stream_last_i,
    .cmd_valid_o (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (q_full)
  );

  bpsd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .cmd_o      (head_cmd),
    .pop_i      (q_pop)
  );

  bpsd_back #(.MAX_RUN(MAX_RUN)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o, .out_stall_i, .out_byte_o, .status_o, .run_last_o, .block_end_o
  );

endmodule
`default_nettype wire

>>> sv/bpsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bpsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] status_o,
  input logic       run_last_o,
  input logic       block_end_o
);
  import bpsd_pkg::*;

  `ASSERT_NEVER(a_status_code, out_valid_o && status_o != ST_DATA && status_o != ST_BAD_HDR && status_o != ST_OVERFLOW, "bad status code")
  `ASSERT_HOLDS(a_err_single, out_valid_o && status_o != ST_DATA |-> run_last_o && out_byte_o == 8'd0, "error result not single")
  `ASSERT_HOLDS(a_bend_last, out_valid_o && block_end_o |-> run_last_o && status_o != ST_BAD_HDR, "block end on wrong result")
  `ASSERT_HOLDS(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(status_o), "stalled result changed")

endmodule

bind byte_pair_stream_decoder bpsd_checker u_bpsd_checker (.*);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import bpsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int NUM_RANDOM     = 450;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } in_item_t;

  typedef struct {
    logic [7:0] ob;
    logic [1:0] st;
    logic       rl;
    logic       be;
  } dec_out_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       stream_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_last_o;
  logic       block_end_o;

  byte_pair_stream_decoder dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  in_item_t   pending[$];
  dec_out_t   decoded_q[$];
  bit         failed = 1'b0;
  bit         in_fire = 1'b0;
  int         accepted_in = 0;
  int         idle_cycles = 0;

  // decoder shadow state
  phase_e      phase = PH_FIRST_HI;
  logic [7:0]  hdr_hi = '0;
  logic [15:0] remaining = '0;
  logic [15:0] blk_len = '0;
  logic [7:0]  n_subs = '0;
  logic [15:0] pairs[256];
  logic [7:0]  codes[256];
  logic        err = 1'b0;
  logic [16:0] stk[256];
  int          stk_n;

  function automatic bit stk_push(logic [7:0] x, int lvl);
    if (stk_n >= 256) return 1'b0;
    stk[stk_n] = {lvl[8:0], x};
    stk_n++;
    return 1'b1;
  endfunction

  // Expand one data byte, lowest-index substitution applied last.
  function automatic void expand_data(logic [7:0] b, bit blk_last);
    logic [7:0] run[$];
    bit         over;
    bit         found;
    logic [7:0] x;
    int         lvl;
    logic [15:0] p;
    dec_out_t   r;
    over = 1'b0;
    stk_n = 0;
    void'(stk_push(b, int'(n_subs)));
    while (stk_n > 0 && !over) begin
      stk_n--;
      x = stk[stk_n][7:0];
      lvl = int'(stk[stk_n][16:8]);
      found = 1'b0;
      while (lvl > 0) begin
        lvl--;
        if (codes[lvl] == x) begin
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        p = pairs[lvl];
        if (!stk_push(p[7:0], lvl) || !stk_push(p[15:8], lvl)) over = 1'b1;
      end else if (run.size() >= MAX_RUN_DEF - 1) begin
        over = 1'b1;
      end else begin
        run = {run, x};
      end
    end
    if (over) begin
      r = '{8'h00, ST_OVERFLOW, 1'b1, blk_last};
      decoded_q = {decoded_q, r};
    end else begin
      foreach (run[k]) begin
        r.ob = run[k];
        r.st = ST_DATA;
        r.rl = (k == run.size() - 1);
        r.be = r.rl && blk_last;
        decoded_q = {decoded_q, r};
      end
    end
  endfunction

  function automatic void decode_step(logic [7:0] b, logic last);
    dec_out_t r;
    int       pos;
    if (!err) begin
      case (phase)
        PH_FIRST_HI, PH_HI: begin
          hdr_hi = b;
          phase = (phase == PH_FIRST_HI) ? PH_FIRST_LO : PH_LO;
        end
        PH_FIRST_LO: begin
          if (hdr_hi != 0 || b != 0) begin
            err = 1'b1;
            r = '{8'h00, ST_BAD_HDR, 1'b1, 1'b0};
            decoded_q = {decoded_q, r};
            phase = PH_HI;
          end else begin
            phase = PH_COUNT;
          end
        end
        PH_LO: begin
          blk_len = {hdr_hi, b};
          if (blk_len == 0) begin
            phase = PH_COUNT;
          end else if (n_subs > 0) begin
            remaining = {8'd0, n_subs};
            phase = PH_CODES;
          end else begin
            remaining = blk_len;
            phase = PH_DATA;
          end
        end
        PH_COUNT: begin
          n_subs = (b > MAX_SUBS_DEF) ? 8'(MAX_SUBS_DEF) : b;
          if (n_subs == 0) begin
            phase = PH_HI;
          end else begin
            remaining = 16'(2 * n_subs);
            phase = PH_PAIRS;
          end
        end
        PH_PAIRS: begin
          pos = 2 * n_subs - remaining;
          if (pos % 2 == 0) pairs[pos / 2][15:8] = b;
          else pairs[pos / 2][7:0] = b;
          remaining--;
          if (remaining == 0) phase = PH_HI;
        end
        PH_CODES: begin
          codes[8'(n_subs - remaining)] = b;
          remaining--;
          if (remaining == 0) begin
            remaining = blk_len;
            phase = PH_DATA;
          end
        end
        default: begin
          remaining--;
          expand_data(b, remaining == 0);
          if (remaining == 0) phase = PH_HI;
        end
      endcase
    end
    if (last) begin
      phase = PH_FIRST_HI;
      err = 1'b0;
      remaining = '0;
      hdr_hi = '0;
    end
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic void put(logic [7:0] b, logic last = 1'b0);
    in_item_t it;
    it.b = b;
    it.last = last;
    pending = {pending, it};
  endfunction

  // Well-formed stream; optionally cut short at a random byte.
  function automatic void well_formed_stream(int nsub, bit cut);
    in_item_t s[$];
    in_item_t it;
    logic [7:0] base;
    int nblk, len, stop;
    base = 8'($urandom_range(0, 255));
    it.last = 1'b0;
    it.b = 8'h00; s = {s, it}; s = {s, it};
    it.b = 8'(nsub); s = {s, it};
    repeat (2 * nsub) begin
      it.b = 8'(base + $urandom_range(0, 7));
      s = {s, it};
    end
    nblk = $urandom_range(1, 3);
    repeat (nblk) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      it.b = len[15:8]; s = {s, it};
      it.b = len[7:0]; s = {s, it};
      repeat (nsub) begin
        it.b = 8'(base + $urandom_range(0, 7));
        s = {s, it};
      end
      repeat (len) begin
        it.b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'(base + $urandom_range(0, 7));
        s = {s, it};
      end
    end
    stop = cut ? $urandom_range(0, s.size() - 1) : s.size() - 1;
    for (int i = 0; i <= stop; i++) put(s[i].b, i == stop);
  endfunction

  function automatic int pick_nsub();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 98) return $urandom_range(1, 6);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- driver ----------------
  int gap = 0;
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin
    in_item_t it;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        gap--;
      end else if (pending.size() > 0) begin
        it = pending.pop_front();
        in_valid_i <= 1'b1;
        in_byte_i <= it.b;
        stream_last_i <= it.last;
        gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps going.
  int  hold = 0;
  bit  held_once = 1'b0;
  always @(negedge clk_i) begin
    int roll;
    if (hold > 0) begin
      out_stall_i <= 1'b1;
      hold--;
    end else if (!held_once && accepted_in >= 150) begin
      held_once = 1'b1;
      hold = 400;
      out_stall_i <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_stall_i <= 1'b0;
      end else if (roll < 97) begin
        out_stall_i <= 1'b1;
      end else begin
        hold = $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  // ---------------- monitor and checker ----------------
  always @(posedge clk_i) begin
    dec_out_t e;
    bit       out_fire;
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      decode_step(in_byte_i, stream_last_i);
      accepted_in++;
    end
    if (out_fire) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected transfer byte=%h status=%0d", $realtime, out_byte_o,
                 status_o);
        failed = 1'b1;
      end else begin
        e = decoded_q.pop_front();
        if (out_byte_o !== e.ob || status_o !== e.st || run_last_o !== e.rl ||
            block_end_o !== e.be) begin
          $display("%0t: mismatch expected byte=%h status=%0d run_last=%b block_end=%b",
                   $realtime, e.ob, e.st, e.rl, e.be);
          $display("%0t:          actual   byte=%h status=%0d run_last=%b block_end=%b",
                   $realtime, out_byte_o, status_o, run_last_o, block_end_o);
          failed = 1'b1;
        end
      end
    end
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int r;
    // init with no substitutions, data passes straight through
    put(8'h00); put(8'h00); put(8'h00);
    put(8'h00); put(8'h02); put(8'h00); put(8'hFF);
    // init block with a chain of doubling substitutions: overflow
    put(8'h00, 1'b1);
    put(8'h00); put(8'h00); put(8'h07);
    repeat (7) begin put(8'hA5); put(8'hA5); end
    put(8'h00); put(8'h02);
    repeat (7) put(8'hA5);
    put(8'hA5); put(8'h3C, 1'b1);
    // bad opening size words, one-byte stream, partial header
    put(8'h01); put(8'h00); put(8'h55); put(8'h00, 1'b1);
    put(8'h00); put(8'h80, 1'b1);
    put(8'hFF, 1'b1);
    put(8'h00); put(8'h00, 1'b1);
    while (pending.size() < NUM_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        well_formed_stream(pick_nsub(), 1'b0);
      end else if (r < 88) begin
        well_formed_stream(pick_nsub(), 1'b1);
      end else if (r < 95) begin
        put(8'($urandom_range(1, 255))); put(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        put(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending.size() > 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() > 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/bpsd_pkg.sv
sv/bpsd_front.sv
sv/bpsd_queue.sv
sv/bpsd_back.sv
sv/byte_pair_stream_decoder.sv
sv/bpsd_checker.sv
bench/tb.sv
